[rtl/affine_rect_bounding_box_core_defines.svh]
// Assertion macros shared by the bounding box RTL.
// The enclosing module must provide clk and rst_n.
`ifndef AFFINE_RECT_BOUNDING_BOX_CORE_DEFINES_SVH
`define AFFINE_RECT_BOUNDING_BOX_CORE_DEFINES_SVH

`ifndef SYNTH
`define ARBB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ARBB_ASSERT_LAT(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);
`else
`define ARBB_ASSERT(label, ante, cons, msg)
`define ARBB_ASSERT_LAT(label, ante, n, cons, msg)
`endif

`endif

[rtl/arbb_pkg.sv]
package arbb_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned ProdW  = 2 * CoordW - FracW;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned SpanW  = CoordW - 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [SpanW-1:0]         span_t;

  localparam coord_t Q_ZERO    = 32'sh0000_0000;
  localparam coord_t Q_ONE     = 32'sh0001_0000;
  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam span_t  SPAN_MAX  = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    REG_COEF_XX = 3'd0,
    REG_COEF_XY = 3'd1,
    REG_COEF_YX = 3'd2,
    REG_COEF_YY = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    coord_t coef_xx;
    coord_t coef_xy;
    coord_t coef_yx;
    coord_t coef_yy;
    coord_t shift_x;
    coord_t shift_y;
  } affine_t;

  function automatic coord_t sat_s33(input logic signed [CoordW:0] v);
    coord_t res;
    if (v[CoordW] == v[CoordW-1]) begin
      res = v[CoordW-1:0];
    end else if (v[CoordW]) begin
      res = COORD_MIN;
    end else begin
      res = COORD_MAX;
    end
    return res;
  endfunction

  function automatic coord_t sat_sum(input sum_t v);
    coord_t res;
    if (v[SumW-1:CoordW-1] == {(SumW-CoordW+1){v[SumW-1]}}) begin
      res = v[CoordW-1:0];
    end else if (v[SumW-1]) begin
      res = COORD_MIN;
    end else begin
      res = COORD_MAX;
    end
    return res;
  endfunction

endpackage

[rtl/arbb_corner.sv]
module arbb_corner
  import arbb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   vld_in,
  input  coord_t rect_x,
  input  coord_t rect_y,
  input  coord_t rect_w,
  input  coord_t rect_h,
  output logic   vld_out,
  output coord_t cx_r [2],
  output coord_t cy_r [2]
);

  logic   vld_r;
  coord_t x1_nxt;
  coord_t y1_nxt;

  always_comb begin
    x1_nxt = sat_s33({rect_x[CoordW-1], rect_x} + {rect_w[CoordW-1], rect_w});
    y1_nxt = sat_s33({rect_y[CoordW-1], rect_y} + {rect_h[CoordW-1], rect_h});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    cx_r[0] <= rect_x;
    cx_r[1] <= x1_nxt;
    cy_r[0] <= rect_y;
    cy_r[1] <= y1_nxt;
  end

  assign vld_out = vld_r;

endmodule

[rtl/arbb_xform.sv]
module arbb_xform
  import arbb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  affine_t mat,
  input  logic    vld_in,
  input  coord_t  cx [2],
  input  coord_t  cy [2],
  output logic    vld_out,
  output coord_t  mx_r [4],
  output coord_t  my_r [4]
);

  logic                         vld_p_r;
  logic                         vld_s_r;
  logic signed [2*CoordW-1:0]   pxx_nxt [2];
  logic signed [2*CoordW-1:0]   pyx_nxt [2];
  logic signed [2*CoordW-1:0]   pxy_nxt [2];
  logic signed [2*CoordW-1:0]   pyy_nxt [2];
  prod_t                        pxx_r [2];
  prod_t                        pyx_r [2];
  prod_t                        pxy_r [2];
  prod_t                        pyy_r [2];
  coord_t                       mx_nxt [4];
  coord_t                       my_nxt [4];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pxx_nxt[i] = mat.coef_xx * cx[i];
      pxy_nxt[i] = mat.coef_xy * cx[i];
      pyx_nxt[i] = mat.coef_yx * cy[i];
      pyy_nxt[i] = mat.coef_yy * cy[i];
    end
  end

  // Dropping the low fraction bits of a two's complement product rounds
  // toward minus infinity.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      pxx_r[i] <= pxx_nxt[i][2*CoordW-1:FracW];
      pxy_r[i] <= pxy_nxt[i][2*CoordW-1:FracW];
      pyx_r[i] <= pyx_nxt[i][2*CoordW-1:FracW];
      pyy_r[i] <= pyy_nxt[i][2*CoordW-1:FracW];
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        mx_nxt[2*i+j] = sat_sum({{2{pxx_r[i][ProdW-1]}}, pxx_r[i]}
                              + {{2{pyx_r[j][ProdW-1]}}, pyx_r[j]}
                              + {{(SumW-CoordW){mat.shift_x[CoordW-1]}}, mat.shift_x});
        my_nxt[2*i+j] = sat_sum({{2{pxy_r[i][ProdW-1]}}, pxy_r[i]}
                              + {{2{pyy_r[j][ProdW-1]}}, pyy_r[j]}
                              + {{(SumW-CoordW){mat.shift_y[CoordW-1]}}, mat.shift_y});
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      mx_r[k] <= mx_nxt[k];
      my_r[k] <= my_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r <= 1'b0;
      vld_s_r <= 1'b0;
    end else begin
      vld_p_r <= vld_in;
      vld_s_r <= vld_p_r;
    end
  end

  assign vld_out = vld_s_r;

endmodule

[rtl/arbb_extent.sv]
`include "affine_rect_bounding_box_core_defines.svh"

module arbb_extent
  import arbb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   vld_in,
  input  coord_t mx [4],
  input  coord_t my [4],
  output logic   vld_out,
  output coord_t box_x_r,
  output coord_t box_y_r,
  output span_t  box_w_r,
  output span_t  box_h_r
);

  logic   vld_pair_r;
  logic   vld_fin_r;
  logic   vld_out_r;
  coord_t minx_pair_r [2];
  coord_t maxx_pair_r [2];
  coord_t miny_pair_r [2];
  coord_t maxy_pair_r [2];
  coord_t minx_r;
  coord_t maxx_r;
  coord_t miny_r;
  coord_t maxy_r;
  logic signed [CoordW:0] dx_nxt;
  logic signed [CoordW:0] dy_nxt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      minx_pair_r[i] <= (mx[2*i+1] < mx[2*i]) ? mx[2*i+1] : mx[2*i];
      maxx_pair_r[i] <= (mx[2*i+1] > mx[2*i]) ? mx[2*i+1] : mx[2*i];
      miny_pair_r[i] <= (my[2*i+1] < my[2*i]) ? my[2*i+1] : my[2*i];
      maxy_pair_r[i] <= (my[2*i+1] > my[2*i]) ? my[2*i+1] : my[2*i];
    end
  end

  always_ff @(posedge clk) begin
    minx_r <= (minx_pair_r[1] < minx_pair_r[0]) ? minx_pair_r[1] : minx_pair_r[0];
    maxx_r <= (maxx_pair_r[1] > maxx_pair_r[0]) ? maxx_pair_r[1] : maxx_pair_r[0];
    miny_r <= (miny_pair_r[1] < miny_pair_r[0]) ? miny_pair_r[1] : miny_pair_r[0];
    maxy_r <= (maxy_pair_r[1] > maxy_pair_r[0]) ? maxy_pair_r[1] : maxy_pair_r[0];
  end

  always_comb begin
    dx_nxt = {maxx_r[CoordW-1], maxx_r} - {minx_r[CoordW-1], minx_r};
    dy_nxt = {maxy_r[CoordW-1], maxy_r} - {miny_r[CoordW-1], miny_r};
  end

  // The spans are never negative, so only the upper limit needs saturation.
  always_ff @(posedge clk) begin
    box_x_r <= minx_r;
    box_y_r <= miny_r;
    box_w_r <= (dx_nxt[CoordW:CoordW-1] != 2'b00) ? SPAN_MAX : dx_nxt[SpanW-1:0];
    box_h_r <= (dy_nxt[CoordW:CoordW-1] != 2'b00) ? SPAN_MAX : dy_nxt[SpanW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_pair_r <= 1'b0;
      vld_fin_r  <= 1'b0;
      vld_out_r  <= 1'b0;
    end else begin
      vld_pair_r <= vld_in;
      vld_fin_r  <= vld_pair_r;
      vld_out_r  <= vld_fin_r;
    end
  end

  assign vld_out = vld_out_r;

  `ARBB_ASSERT(a_min_le_max_x, vld_fin_r, minx_r <= maxx_r, "x minimum exceeds x maximum")
  `ARBB_ASSERT(a_min_le_max_y, vld_fin_r, miny_r <= maxy_r, "y minimum exceeds y maximum")

endmodule

[rtl/affine_rect_bounding_box_core.sv]
// Affine rectangle bounding box, signed Q16.16.
// Input transaction: in_rect_x, in_rect_y, in_rect_w and in_rect_h are taken at a
// rising clock edge with start high and busy low. busy is low except during reset,
// so a new rectangle may be issued in every cycle.
// Each corner is mapped through the affine matrix held in six configuration
// registers, and the axis-aligned bounding box of the four mapped corners is
// returned as out_box_x, out_box_y (minimum corner) and out_box_w, out_box_h
// (saturated size).
// Configuration: cfg_we writes cfg_wdata into the register selected by cfg_idx
// (0 coef_xx, 1 coef_xy, 2 coef_yx, 3 coef_yy, 4 shift_x, 5 shift_y); other
// indexes are ignored. Write only while no transaction is in flight.
// Corner sums, eight parallel 32x32 multipliers, the saturating adds, two
// compare levels and the span subtract each own a pipeline stage.
// Throughput is one transaction per cycle.
// Each result is shown for exactly one cycle with out_valid high; the receiver
// cannot stall, so no backpressure exists in the pipeline.
// Reset clears all valid bits and loads the identity matrix.
`include "affine_rect_bounding_box_core_defines.svh"

module affine_rect_bounding_box_core
  import arbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  coord_t      in_rect_x,
  input  coord_t      in_rect_y,
  input  coord_t      in_rect_w,
  input  coord_t      in_rect_h,
  output logic        out_valid,
  output coord_t      out_box_x,
  output coord_t      out_box_y,
  output span_t       out_box_w,
  output span_t       out_box_h,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  affine_t mat_r;
  logic    accept;
  logic    vld_c;
  logic    vld_m;
  coord_t  cx [2];
  coord_t  cy [2];
  coord_t  mx [4];
  coord_t  my [4];

  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r.coef_xx <= Q_ONE;
      mat_r.coef_xy <= Q_ZERO;
      mat_r.coef_yx <= Q_ZERO;
      mat_r.coef_yy <= Q_ONE;
      mat_r.shift_x <= Q_ZERO;
      mat_r.shift_y <= Q_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COEF_XX: mat_r.coef_xx <= cfg_wdata;
        REG_COEF_XY: mat_r.coef_xy <= cfg_wdata;
        REG_COEF_YX: mat_r.coef_yx <= cfg_wdata;
        REG_COEF_YY: mat_r.coef_yy <= cfg_wdata;
        REG_SHIFT_X: mat_r.shift_x <= cfg_wdata;
        REG_SHIFT_Y: mat_r.shift_y <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  arbb_corner u_corner (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (accept),
    .rect_x  (in_rect_x),
    .rect_y  (in_rect_y),
    .rect_w  (in_rect_w),
    .rect_h  (in_rect_h),
    .vld_out (vld_c),
    .cx_r    (cx),
    .cy_r    (cy)
  );

  arbb_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .mat     (mat_r),
    .vld_in  (vld_c),
    .cx      (cx),
    .cy      (cy),
    .vld_out (vld_m),
    .mx_r    (mx),
    .my_r    (my)
  );

  arbb_extent u_extent (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (vld_m),
    .mx      (mx),
    .my      (my),
    .vld_out (out_valid),
    .box_x_r (out_box_x),
    .box_y_r (out_box_y),
    .box_w_r (out_box_w),
    .box_h_r (out_box_h)
  );

  `ARBB_ASSERT_LAT(a_result_latency, accept, 6, out_valid, "accepted transaction gave no result")

endmodule
